FILE: rtl/fan_speed_and_power_button_controller_unit_defines.svh
// Assertion macros shared by the fan controller RTL.
// Both macros expect signals named clk and rst_n in the calling module.
`ifndef FAN_SPEED_AND_POWER_BUTTON_CONTROLLER_UNIT_DEFINES_SVH
`define FAN_SPEED_AND_POWER_BUTTON_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/fsbc_pkg.sv
package fsbc_pkg;

    localparam int unsigned TEMP_W      = 10;
    localparam int unsigned DUTY_W      = 8;
    localparam int unsigned CNT8_W      = 8;
    localparam int unsigned CFG_W       = 10;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned TOTAL_W     = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 64;

    // Division by the sample count is a multiply by a rounded-up reciprocal.
    // With a shift of TOTAL_W + 6 the quotient is exact for counts up to 64.
    localparam int unsigned RECIP_SHIFT = TOTAL_W + 6;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [DUTY_W-1:0] UPPER_DUTY_LIMIT = 8'd240;

    localparam logic [TEMP_W-1:0] OVERHEAT_LEVEL_RST  = 10'd800;
    localparam logic [TEMP_W-1:0] FLOOR_LEVEL_RST     = 10'd565;
    localparam logic [TEMP_W-1:0] DUTY_OFFSET_RST     = 10'd560;
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST        = 8'd30;
    localparam logic [DUTY_W-1:0] HOT_DUTY_RST        = 8'd254;
    localparam logic [CNT8_W-1:0] CHECK_PERIOD_RST    = 8'd100;
    localparam logic [CNT8_W-1:0] SHORT_PRESS_MIN_RST = 8'd2;
    localparam logic [CNT8_W-1:0] LONG_PRESS_MIN_RST  = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERHEAT_LEVEL  = 3'd0,
        CFG_FLOOR_LEVEL     = 3'd1,
        CFG_DUTY_OFFSET     = 3'd2,
        CFG_MIN_DUTY        = 3'd3,
        CFG_HOT_DUTY        = 3'd4,
        CFG_CHECK_PERIOD    = 3'd5,
        CFG_SHORT_PRESS_MIN = 3'd6,
        CFG_LONG_PRESS_MIN  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TEMP_W-1:0] overheat_level;
        logic [TEMP_W-1:0] floor_level;
        logic [TEMP_W-1:0] duty_offset;
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] hot_duty;
        logic [CNT8_W-1:0] check_period;
        logic [CNT8_W-1:0] short_press_min;
        logic [CNT8_W-1:0] long_press_min;
    } cfg_t;

    // Packed so that the first field sits in the highest bits.
    typedef struct packed {
        logic              button_down;
        logic [TEMP_W-1:0] temp_sample;
    } item_t;

    typedef struct packed {
        logic              overheated;
        logic              power_enabled;
        logic              duty_updated;
        logic [DUTY_W-1:0] duty_level;
    } result_t;

endpackage

FILE: rtl/fsbc_cfg.sv
module fsbc_cfg
    import fsbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_OVERHEAT_LEVEL:  cfg_next.overheat_level  = cfg_data[TEMP_W-1:0];
                CFG_FLOOR_LEVEL:     cfg_next.floor_level     = cfg_data[TEMP_W-1:0];
                CFG_DUTY_OFFSET:     cfg_next.duty_offset     = cfg_data[TEMP_W-1:0];
                CFG_MIN_DUTY:        cfg_next.min_duty        = cfg_data[DUTY_W-1:0];
                CFG_HOT_DUTY:        cfg_next.hot_duty        = cfg_data[DUTY_W-1:0];
                CFG_CHECK_PERIOD:    cfg_next.check_period    = cfg_data[CNT8_W-1:0];
                CFG_SHORT_PRESS_MIN: cfg_next.short_press_min = cfg_data[CNT8_W-1:0];
                CFG_LONG_PRESS_MIN:  cfg_next.long_press_min  = cfg_data[CNT8_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overheat_level  <= OVERHEAT_LEVEL_RST;
            cfg_reg.floor_level     <= FLOOR_LEVEL_RST;
            cfg_reg.duty_offset     <= DUTY_OFFSET_RST;
            cfg_reg.min_duty        <= MIN_DUTY_RST;
            cfg_reg.hot_duty        <= HOT_DUTY_RST;
            cfg_reg.check_period    <= CHECK_PERIOD_RST;
            cfg_reg.short_press_min <= SHORT_PRESS_MIN_RST;
            cfg_reg.long_press_min  <= LONG_PRESS_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/fsbc_in_reg.sv
module fsbc_in_reg
    import fsbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  pop,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new item when the register is empty or the held one leaves in the same cycle.
    assign in_ready = !valid_reg || pop;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

FILE: rtl/fsbc_core.sv
`include "fan_speed_and_power_button_controller_unit_defines.svh"

module fsbc_core
    import fsbc_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int unsigned PROD_W = TOTAL_W + RECIP_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1)
                 / 64'(SAMPLES_PER_AVERAGE));

    logic [TOTAL_W-1:0] total_reg,     total_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT8_W-1:0]  ticks_reg,     ticks_next;
    logic [CNT8_W-1:0]  hold_reg,      hold_next;
    logic [CNT8_W-1:0]  last_hold_reg, last_hold_next;
    logic               press_reg,     press_next;
    logic               release_reg,   release_next;
    logic               hot_reg,       hot_next;
    logic               power_reg,     power_next;
    logic [DUTY_W-1:0]  duty_reg,      duty_next;

    logic [TOTAL_W-1:0] total_sum;
    logic [CNT_W-1:0]   count_inc;
    logic               due;
    logic [PROD_W-1:0]  product;
    logic [TOTAL_W-1:0] avg;
    logic [TEMP_W-1:0]  floored;
    logic [TEMP_W-1:0]  diff;
    logic               avg_hot;
    logic [DUTY_W-1:0]  avg_duty;
    logic [CNT8_W-1:0]  ticks_inc;

    assign total_sum = total_reg + TOTAL_W'(item.temp_sample);
    assign count_inc = count_reg + CNT_W'(1);
    assign due       = (count_inc == CNT_LAST);

    assign product = PROD_W'(total_sum) * PROD_W'(RECIP);
    assign avg     = product[RECIP_SHIFT +: TOTAL_W];

    // Below the overheat level the average fits the sample width.
    assign floored = (avg[TEMP_W-1:0] < cfg.floor_level) ? cfg.floor_level
                                                         : avg[TEMP_W-1:0];
    assign diff    = floored - cfg.duty_offset;

    always_comb
    begin
        avg_hot  = 1'b0;
        avg_duty = diff[DUTY_W-1:0];
        if (avg > TOTAL_W'(cfg.overheat_level))
        begin
            avg_hot  = 1'b1;
            avg_duty = cfg.hot_duty;
        end
        else if (floored < cfg.duty_offset)
        begin
            avg_duty = cfg.hot_duty;
        end
        else if (diff < TEMP_W'(cfg.min_duty))
        begin
            avg_duty = '0;
        end
        else if (diff > TEMP_W'(UPPER_DUTY_LIMIT))
        begin
            avg_duty = cfg.hot_duty;
        end
    end

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + CNT8_W'(1);

    always_comb
    begin
        total_next     = due ? '0 : total_sum;
        count_next     = due ? '0 : count_inc;
        hot_next       = due ? avg_hot : hot_reg;
        duty_next      = due ? avg_duty : duty_reg;
        ticks_next     = ticks_inc;
        hold_next      = hold_reg;
        last_hold_next = last_hold_reg;
        press_next     = press_reg;
        release_next   = release_reg;
        power_next     = power_reg;

        if (hot_next)
        begin
            power_next = 1'b0;
        end
        else if (ticks_inc > cfg.check_period)
        begin
            ticks_next = '0;
            if (item.button_down)
            begin
                hold_next      = hold_reg + CNT8_W'(1);
                last_hold_next = hold_next;
            end
            else
            begin
                hold_next = '0;
            end
            if (hold_next != '0)
                press_next = 1'b1;
            if (press_next && hold_next == '0)
                release_next = 1'b1;
            // Short press first; the long-press test then sees the cleared count.
            if (last_hold_next > cfg.short_press_min && release_next)
            begin
                press_next     = 1'b0;
                release_next   = 1'b0;
                last_hold_next = '0;
                power_next     = 1'b0;
            end
            if (last_hold_next > cfg.long_press_min)
            begin
                press_next     = 1'b0;
                last_hold_next = '0;
                power_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            count_reg     <= '0;
            ticks_reg     <= '0;
            hold_reg      <= '0;
            last_hold_reg <= '0;
            press_reg     <= 1'b0;
            release_reg   <= 1'b0;
            hot_reg       <= 1'b0;
            power_reg     <= 1'b0;
            duty_reg      <= '0;
        end
        else if (advance)
        begin
            total_reg     <= total_next;
            count_reg     <= count_next;
            ticks_reg     <= ticks_next;
            hold_reg      <= hold_next;
            last_hold_reg <= last_hold_next;
            press_reg     <= press_next;
            release_reg   <= release_next;
            hot_reg       <= hot_next;
            power_reg     <= power_next;
            duty_reg      <= duty_next;
        end
    end

    assign result.duty_level    = duty_next;
    assign result.duty_updated  = due;
    assign result.power_enabled = power_next;
    assign result.overheated    = hot_next;

    `ASSERT_CLK(a_count_below_last, count_reg < CNT_LAST, "sample count overrun")
    `ASSERT_CLK(a_hot_power_off, hot_reg |-> !power_reg, "power on while overheated")
    `ASSERT_NEXT(a_count_clear, advance && due, count_reg == '0 && total_reg == '0, "sum not cleared")

endmodule

FILE: rtl/fsbc_out_reg.sv
module fsbc_out_reg
    import fsbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t in_result,
    input  logic    out_ready,
    output logic    valid,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= in_result;
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/fan_speed_and_power_button_controller_unit.sv
// Channel   Direction  Payload
// s_axis    in         temp_sample, button_down (one item = one tick)
// m_axis    out        duty_level, duty_updated, power_enabled, overheated
// cfg       in         write only, one register per write, no wait
//
// Each item passes through the input register, then the
// accumulate/average/button update into the result register.
// One item per cycle sustained while the output is not stalled; the average divide is a constant reciprocal
// multiply, the single multiplier in the update path.
// rst_n clears all counters and flags and loads the register defaults.
// A stalled output holds its item; the input keeps accepting while its register is empty or the
// held item can move into the result register in the same cycle.
`include "fan_speed_and_power_button_controller_unit_defines.svh"

module fan_speed_and_power_button_controller_unit
    import fsbc_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [9:0] temp_sample, [10] button_down, [15:11] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] duty_level, [8] duty_updated, [9] power_enabled, [10] overheated,
    // [15:11] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int unsigned OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t core_result;
    result_t out_result;

    // Move the held item into the result register when that slot is free.
    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    fsbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsbc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (item_t'(s_axis_tdata[$bits(item_t)-1:0])),
        .pop      (advance),
        .valid    (item_valid),
        .item     (item)
    );

    fsbc_core #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (core_result)
    );

    fsbc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .in_result (core_result),
        .out_ready (m_axis_tready),
        .valid     (m_axis_tvalid),
        .result    (out_result)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_result};

endmodule

FILE: verif/fan_speed_and_power_button_controller_unit_tb.sv
class fan_ctrl_scoreboard;
    fsbc_pkg::cfg_t    regs;
    logic [15:0]       sample_sum;
    logic [6:0]        sample_cnt;
    logic [7:0]        tick_cnt;
    logic [7:0]        held_checks;
    logic [7:0]        last_held;
    bit                pressed;
    bit                released;
    bit                hot;
    bit                powered;
    logic [7:0]        duty;
    fsbc_pkg::result_t pending_q[$];
    int unsigned       errors;

    function new();
        regs.overheat_level  = fsbc_pkg::OVERHEAT_LEVEL_RST;
        regs.floor_level     = fsbc_pkg::FLOOR_LEVEL_RST;
        regs.duty_offset     = fsbc_pkg::DUTY_OFFSET_RST;
        regs.min_duty        = fsbc_pkg::MIN_DUTY_RST;
        regs.hot_duty        = fsbc_pkg::HOT_DUTY_RST;
        regs.check_period    = fsbc_pkg::CHECK_PERIOD_RST;
        regs.short_press_min = fsbc_pkg::SHORT_PRESS_MIN_RST;
        regs.long_press_min  = fsbc_pkg::LONG_PRESS_MIN_RST;
        sample_sum  = '0;
        sample_cnt  = '0;
        tick_cnt    = '0;
        held_checks = '0;
        last_held   = '0;
        pressed     = 1'b0;
        released    = 1'b0;
        hot         = 1'b0;
        powered     = 1'b0;
        duty        = '0;
        errors      = 0;
    endfunction

    function void write_reg(fsbc_pkg::cfg_index_t idx, logic [9:0] value);
        case (idx)
            fsbc_pkg::CFG_OVERHEAT_LEVEL:  regs.overheat_level  = value;
            fsbc_pkg::CFG_FLOOR_LEVEL:     regs.floor_level     = value;
            fsbc_pkg::CFG_DUTY_OFFSET:     regs.duty_offset     = value;
            fsbc_pkg::CFG_MIN_DUTY:        regs.min_duty        = value[7:0];
            fsbc_pkg::CFG_HOT_DUTY:        regs.hot_duty        = value[7:0];
            fsbc_pkg::CFG_CHECK_PERIOD:    regs.check_period    = value[7:0];
            fsbc_pkg::CFG_SHORT_PRESS_MIN: regs.short_press_min = value[7:0];
            fsbc_pkg::CFG_LONG_PRESS_MIN:  regs.long_press_min  = value[7:0];
            default: ;
        endcase
    endfunction

    function void refresh_duty();
        int unsigned avg;
        int unsigned level;
        avg = sample_sum / fsbc_pkg::SAMPLES_PER_AVERAGE_DEF;
        sample_sum = '0;
        sample_cnt = '0;
        if (avg > regs.overheat_level)
        begin
            hot  = 1'b1;
            duty = regs.hot_duty;
            return;
        end
        hot = 1'b0;
        if (avg < regs.floor_level)
            avg = regs.floor_level;
        // offset above the floored average counts as past the upper limit
        if (avg < regs.duty_offset)
        begin
            duty = regs.hot_duty;
            return;
        end
        level = avg - regs.duty_offset;
        if (level < regs.min_duty)
            level = 0;
        if (level > fsbc_pkg::UPPER_DUTY_LIMIT)
            level = regs.hot_duty;
        duty = 8'(level);
    endfunction

    function void poll_button(bit down);
        if (down)
        begin
            held_checks = held_checks + 8'd1;
            last_held   = held_checks;
        end
        else
        begin
            held_checks = '0;
        end
        if (held_checks != 0)
            pressed = 1'b1;
        // a wrapped hold counter reads as a release
        if (pressed && held_checks == 0)
            released = 1'b1;
        if (last_held > regs.short_press_min && released)
        begin
            pressed   = 1'b0;
            released  = 1'b0;
            last_held = '0;
            powered   = 1'b0;
        end
        if (last_held > regs.long_press_min)
        begin
            pressed   = 1'b0;
            last_held = '0;
            powered   = 1'b1;
        end
    endfunction

    function void note_item(fsbc_pkg::item_t it);
        fsbc_pkg::result_t r;
        bit                averaged;
        sample_sum = sample_sum + 16'(it.temp_sample);
        sample_cnt = sample_cnt + 7'd1;
        if (tick_cnt != 8'hFF)
            tick_cnt = tick_cnt + 8'd1;
        averaged = (sample_cnt >= fsbc_pkg::SAMPLES_PER_AVERAGE_DEF);
        if (averaged)
            refresh_duty();
        if (hot)
        begin
            powered = 1'b0;
        end
        else if (tick_cnt > regs.check_period)
        begin
            tick_cnt = '0;
            poll_button(it.button_down);
        end
        r.duty_level    = duty;
        r.duty_updated  = averaged;
        r.power_enabled = powered;
        r.overheated    = hot;
        pending_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    function void check_result(logic [fsbc_pkg::OUT_TDATA_W-1:0] data);
        fsbc_pkg::result_t got;
        fsbc_pkg::result_t want;
        got = fsbc_pkg::result_t'(data[$bits(fsbc_pkg::result_t)-1:0]);
        if (pending_q.size() == 0)
        begin
            errors++;
            $display("%0t: item with nothing expected, expected none, actual %h",
                     $time, data);
            return;
        end
        want = pending_q.pop_front();
        compare_field("duty_level", want.duty_level, got.duty_level);
        compare_field("duty_updated", 8'(want.duty_updated), 8'(got.duty_updated));
        compare_field("power_enabled", 8'(want.power_enabled), 8'(got.power_enabled));
        compare_field("overheated", 8'(want.overheated), 8'(got.overheated));
    endfunction

    function bit drained();
        return pending_q.size() == 0;
    endfunction
endclass

module fan_speed_and_power_button_controller_unit_tb
    import fsbc_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned PHASE_ITEMS      = 140;
    localparam int unsigned WRAP_PHASE_ITEMS = 400;
    localparam int unsigned PHASE_COUNT      = 10;
    localparam int unsigned HOLD_OFF_CYCLES  = 300;
    localparam int unsigned DIRECTED_ITEMS   = 25;
    localparam logic [DIRECTED_ITEMS-1:0] DIRECTED_BUTTON = 25'b0100111110111010111110110;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    fan_ctrl_scoreboard sb;
    int unsigned        cycles = 0;
    int unsigned        items_sent;
    int unsigned        burst_left;
    int unsigned        button_run;
    int                 temp_target;
    int                 temp_spread;
    bit                 block_random;
    bit                 button_level;
    bit                 hold_off_request;

    fan_speed_and_power_button_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Receiver: steady, random and stalled stretches, plus a long hold-off on request.
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
            repeat (span)
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= 1'b0;
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic load_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic program_regs(logic [9:0] overheat, logic [9:0] floor_lvl,
                                logic [9:0] offset, logic [7:0] min_d, logic [7:0] hot_d,
                                logic [7:0] period, logic [7:0] short_min,
                                logic [7:0] long_min);
        load_reg(CFG_OVERHEAT_LEVEL, overheat);
        load_reg(CFG_FLOOR_LEVEL, floor_lvl);
        load_reg(CFG_DUTY_OFFSET, offset);
        load_reg(CFG_MIN_DUTY, CFG_W'(min_d));
        load_reg(CFG_HOT_DUTY, CFG_W'(hot_d));
        load_reg(CFG_CHECK_PERIOD, CFG_W'(period));
        load_reg(CFG_SHORT_PRESS_MIN, CFG_W'(short_min));
        load_reg(CFG_LONG_PRESS_MIN, CFG_W'(long_min));
        cfg_we <= 1'b0;
    endtask

    // Hold the item until the block takes it, then record it.
    task automatic send_item(item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(it);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic wait_drained();
        while (!sb.drained())
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Blocks of 64 samples, mostly aimed at a threshold; button runs sized in checks.
    function automatic item_t next_item();
        item_t       it;
        int          t;
        int unsigned checks;
        int unsigned span;
        if (items_sent % SAMPLES_PER_AVERAGE_DEF == 0)
        begin
            block_random = ($urandom_range(0, 7) == 0);
            temp_spread  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20)) : 0;
            case ($urandom_range(0, 9))
                0: temp_target = int'(sb.regs.overheat_level);
                1: temp_target = int'(sb.regs.overheat_level) + 1;
                2: temp_target = int'(sb.regs.floor_level) - 1;
                3: temp_target = int'(sb.regs.floor_level);
                4: temp_target = int'(sb.regs.duty_offset) + int'(sb.regs.min_duty) - 1;
                5: temp_target = int'(sb.regs.duty_offset) + int'(sb.regs.min_duty);
                6: temp_target = int'(sb.regs.duty_offset) + int'(UPPER_DUTY_LIMIT);
                7: temp_target = int'(sb.regs.duty_offset) + int'(UPPER_DUTY_LIMIT) + 1;
                8: temp_target = ($urandom_range(0, 1) != 0) ? 1023 : 0;
                default: temp_target = int'($urandom_range(0, 1023));
            endcase
        end
        t = temp_target + int'($urandom_range(0, 2 * temp_spread)) - temp_spread;
        if (block_random)
            t = int'($urandom_range(0, 1023));
        if (t < 0)
            t = 0;
        if (t > 1023)
            t = 1023;
        it.temp_sample = t[9:0];

        if (button_run == 0)
        begin
            button_level = ~button_level;
            case ($urandom_range(0, 7))
                0: checks = sb.regs.short_press_min + 1;
                1: checks = sb.regs.short_press_min;
                2: checks = sb.regs.long_press_min + 1;
                3: checks = sb.regs.long_press_min;
                4: checks = 1;
                5: checks = 256 + $urandom_range(0, 6);
                default: checks = $urandom_range(1, 6);
            endcase
            // push the hold counter past its wrap when nothing else ends the hold
            if (button_level && sb.regs.long_press_min == 8'hFF && $urandom_range(0, 1))
                checks = 256 + $urandom_range(0, 6);
            if (sb.regs.check_period == 8'hFF)
                span = $urandom_range(1, 300);
            else
                span = checks * (sb.regs.check_period + 1);
            if (span == 0 || span > 600)
                span = $urandom_range(1, 600);
            button_run = span;
        end
        button_run--;
        it.button_down = button_level;
        if ($urandom_range(0, 39) == 0)
            it.button_down = ~button_level;
        items_sent++;
        return it;
    endfunction

    task automatic run_phase(int unsigned count);
        int unsigned gap;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
            end
            burst_left--;
            send_item(next_item());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int    directed_temps [5];
        item_t it;
        directed_temps = '{0, 1023, 341, 682, 512};
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_OVERHEAT_LEVEL;
        cfg_data      <= '0;
        hold_off_request = 1'b0;
        button_level     = 1'b0;
        button_run       = 0;
        burst_left       = 0;
        items_sent       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Check the button on every item so short presses, long holds and
        // releases all fit in a short sequence.
        program_regs(10'd1023, 10'd0, 10'd0, 8'd0, 8'd255, 8'd0, 8'd1, 8'd3);
        for (int k = 0; k < DIRECTED_ITEMS; k++)
        begin
            it.temp_sample = 10'(directed_temps[k % 5]);
            it.button_down = DIRECTED_BUTTON[k];
            items_sent++;
            send_item(it);
        end
        s_axis_tvalid <= 1'b0;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_regs(OVERHEAT_LEVEL_RST, FLOOR_LEVEL_RST, DUTY_OFFSET_RST,
                                MIN_DUTY_RST, HOT_DUTY_RST, 8'd1, SHORT_PRESS_MIN_RST,
                                LONG_PRESS_MIN_RST);
                1: program_regs(10'd1023, 10'd0, 10'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
                // button never checked: tick counter saturates
                2: program_regs(10'd0, 10'd1023, 10'd1023, 8'd255, 8'd0, 8'd255, 8'd255,
                                8'd255);
                // offset above the floored average
                3: program_regs(10'd1000, 10'd100, 10'd700, 8'd10, 8'd200, 8'd2, 8'd1, 8'd4);
                // upper duty limit, both press rules at once
                4: program_regs(10'd1023, 10'd0, 10'd50, 8'd5, 8'd77, 8'd0, 8'd3, 8'd3);
                // long holds wrap the hold counter
                5: program_regs(OVERHEAT_LEVEL_RST, FLOOR_LEVEL_RST, DUTY_OFFSET_RST,
                                MIN_DUTY_RST, HOT_DUTY_RST, 8'd0, 8'd2, 8'd255);
                default: program_regs(10'($urandom_range(600, 1023)),
                                      10'($urandom_range(0, 1023)),
                                      10'($urandom_range(0, 800)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 6)),
                                      8'($urandom_range(0, 8)),
                                      8'($urandom_range(0, 30)));
            endcase
            if (phase == 0 || phase == 6)
                hold_off_request = 1'b1;
            run_phase((phase == 5) ? WRAP_PHASE_ITEMS : PHASE_ITEMS);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
